>>> hw/rtl/afr_pkg.sv
// shared types and constants for the addressed frame receiver
`default_nettype none

package afr_pkg;

  // byte codes seen in a frame
  localparam logic [7:0] START_BYTE = 8'h3A;
  localparam logic [7:0] FUNC_TIME  = 8'hF1;
  localparam logic [7:0] FUNC_TEST  = 8'hF3;

  // header byte positions (start byte is position 0)
  localparam logic [15:0] HDR_ADDR   = 16'd1;
  localparam logic [15:0] HDR_FUNC   = 16'd2;
  localparam logic [15:0] HDR_LEN_LO = 16'd3;
  localparam logic [15:0] HDR_LEN_HI = 16'd4;

  // result kinds
  localparam logic KIND_PAYLOAD  = 1'b0;
  localparam logic KIND_COMPLETE = 1'b1;

  // host notify codes
  typedef enum logic [1:0] {
    NOTIFY_NONE = 2'd0,
    NOTIFY_TIME = 2'd1,
    NOTIFY_TEST = 2'd2
  } notify_t;

  // parser phase
  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_HEADER  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  // one registered input word
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } in_word_t;

endpackage

`default_nettype wire

>>> hw/rtl/afr_in_reg.sv
// input register stage for received bytes
`default_nettype none

module afr_in_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_rx_byte,
  input  wire logic             take,
  output afr_pkg::in_word_t     word
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  // room when empty or when the held word moves on this cycle
  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_valid ? 1'b1 : (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  assign word.valid   = valid_r;
  assign word.rx_byte = byte_r;

endmodule

`default_nettype wire

>>> hw/rtl/afr_parser.sv
// frame state tracking and result register
`default_nettype none

module afr_parser (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire afr_pkg::in_word_t word,
  output logic                   take,
  input  wire logic [7:0]        node_address,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_kind,
  output logic [15:0]            out_payload_index,
  output logic [7:0]             out_payload_byte,
  output logic [7:0]             out_frame_function,
  output logic [15:0]            out_payload_length,
  output logic [7:0]             out_subfunction,
  output logic [1:0]             out_notify
);

  // frame state
  afr_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]     count_r, count_nxt;
  logic [7:0]      addr_r, addr_nxt;
  logic [7:0]      func_r, func_nxt;
  logic [15:0]     len_r, len_nxt;
  logic [7:0]      first_r, first_nxt;

  // result register
  logic            out_valid_r, out_valid_nxt;
  logic            kind_r, kind_nxt;
  logic [15:0]     index_r, index_nxt;
  logic [7:0]      pbyte_r, pbyte_nxt;
  logic [7:0]      ofunc_r, ofunc_nxt;
  logic [15:0]     olen_r, olen_nxt;
  logic [7:0]      osub_r, osub_nxt;
  afr_pkg::notify_t notify_r, notify_nxt;

  logic            step;
  logic            emit;
  logic [7:0]      b;

  // a word advances when the result register is free or drains now
  assign take = !out_valid_r || out_ready;
  assign step = word.valid && take;
  assign b    = word.rx_byte;

  // next state and result for one byte
  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    addr_nxt   = addr_r;
    func_nxt   = func_r;
    len_nxt    = len_r;
    first_nxt  = first_r;
    emit       = 1'b0;
    kind_nxt   = afr_pkg::KIND_PAYLOAD;
    index_nxt  = 16'd0;
    pbyte_nxt  = 8'd0;
    ofunc_nxt  = 8'd0;
    olen_nxt   = 16'd0;
    osub_nxt   = 8'd0;
    notify_nxt = afr_pkg::NOTIFY_NONE;
    case (phase_r)
      afr_pkg::PH_IDLE: begin
        // the start byte counts as header position 0
        if (b == afr_pkg::START_BYTE) begin
          phase_nxt = afr_pkg::PH_HEADER;
          count_nxt = afr_pkg::HDR_ADDR;
        end
      end
      afr_pkg::PH_HEADER: begin
        count_nxt = count_r + 16'd1;
        case (count_r)
          afr_pkg::HDR_ADDR:   addr_nxt = b;
          afr_pkg::HDR_FUNC:   func_nxt = b;
          afr_pkg::HDR_LEN_LO: len_nxt  = {len_r[15:8], b};
          afr_pkg::HDR_LEN_HI: begin
            len_nxt   = {b, len_r[7:0]};
            count_nxt = 16'd0;
            // address check on the last header byte
            if (addr_r == node_address) begin
              phase_nxt = afr_pkg::PH_PAYLOAD;
            end else begin
              phase_nxt = afr_pkg::PH_IDLE;
            end
          end
          default: ;
        endcase
      end
      afr_pkg::PH_PAYLOAD: begin
        emit = 1'b1;
        if (count_r < len_r) begin
          if (count_r == 16'd0) begin
            first_nxt = b;
          end
          kind_nxt  = afr_pkg::KIND_PAYLOAD;
          index_nxt = count_r;
          pbyte_nxt = b;
          count_nxt = count_r + 16'd1;
        end else begin
          // end byte: consumed, frame complete
          phase_nxt = afr_pkg::PH_IDLE;
          count_nxt = 16'd0;
          kind_nxt  = afr_pkg::KIND_COMPLETE;
          ofunc_nxt = func_r;
          olen_nxt  = len_r;
          osub_nxt  = first_r;
          if (func_r == afr_pkg::FUNC_TIME) begin
            notify_nxt = afr_pkg::NOTIFY_TIME;
          end else if (func_r == afr_pkg::FUNC_TEST) begin
            notify_nxt = afr_pkg::NOTIFY_TEST;
          end
        end
      end
      default: begin
        phase_nxt = afr_pkg::PH_IDLE;
        count_nxt = 16'd0;
      end
    endcase
  end

  // result valid follows each stepped word
  always_comb begin
    if (step) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= afr_pkg::PH_IDLE;
      count_r     <= 16'd0;
      addr_r      <= 8'd0;
      func_r      <= 8'd0;
      len_r       <= 16'd0;
      first_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (step) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
        addr_r  <= addr_nxt;
        func_r  <= func_nxt;
        len_r   <= len_nxt;
        first_r <= first_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (step && emit) begin
      kind_r   <= kind_nxt;
      index_r  <= index_nxt;
      pbyte_r  <= pbyte_nxt;
      ofunc_r  <= ofunc_nxt;
      olen_r   <= olen_nxt;
      osub_r   <= osub_nxt;
      notify_r <= notify_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_payload_index  = index_r;
  assign out_payload_byte   = pbyte_r;
  assign out_frame_function = ofunc_r;
  assign out_payload_length = olen_r;
  assign out_subfunction    = osub_r;
  assign out_notify         = notify_r;

  // a held payload word lies inside the current frame length
  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == afr_pkg::KIND_PAYLOAD) |-> (index_r < len_r))
    else $error("payload index beyond frame length");

  // a held completion leaves the parser idle with a cleared count
  a_complete_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == afr_pkg::KIND_COMPLETE) |->
      (phase_r == afr_pkg::PH_IDLE && count_r == 16'd0))
    else $error("completion held while parser not idle");

  // header position stays between address and length high
  a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == afr_pkg::PH_HEADER) |->
      (count_r >= afr_pkg::HDR_ADDR && count_r <= afr_pkg::HDR_LEN_HI))
    else $error("header position out of range");

  // only a start byte leaves idle
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == afr_pkg::PH_IDLE && b != afr_pkg::START_BYTE) |=>
      (phase_r == afr_pkg::PH_IDLE))
    else $error("idle left without start byte");

endmodule

`default_nettype wire

>>> hw/rtl/addressed_frame_receiver.sv
// top level of the addressed frame receiver
//
//  channel  | ports                          | direction | word
//  ---------+--------------------------------+-----------+----------------------------
//  in       | in_valid/in_ready/in_rx_byte   | input     | one received byte
//  out      | out_valid/out_ready/out_*      | output    | payload byte or frame done
//  cfg      | cfg_valid/cfg_ready/cfg_node_address | input | node address register
//
//  Each byte passes through the input register and the parser, then its result (if any)
//  sits in the result register; one byte a cycle while out_ready keeps the result register draining.
//  The parser steps a byte whenever the result register is empty or drains that cycle.
//  While out_ready is low the input register still takes one more byte.
//  Reset (rst_n low, synchronous) returns the parser to waiting for a start byte.
//  The config port is always ready; a write takes effect on the next header check.
`default_nettype none

module addressed_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [15:0]      out_payload_index,
  output logic [7:0]       out_payload_byte,
  output logic [7:0]       out_frame_function,
  output logic [15:0]      out_payload_length,
  output logic [7:0]       out_subfunction,
  output logic [1:0]       out_notify,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_node_address
);

  afr_pkg::in_word_t word;
  logic              take;
  logic [7:0]        node_addr_r;

  // node address register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_addr_r <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      node_addr_r <= cfg_node_address;
    end
  end

  // input stage
  afr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .word       (word)
  );

  // parser and result register
  afr_parser u_parser (
    .clk                (clk),
    .rst_n              (rst_n),
    .word               (word),
    .take               (take),
    .node_address       (node_addr_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_payload_index  (out_payload_index),
    .out_payload_byte   (out_payload_byte),
    .out_frame_function (out_frame_function),
    .out_payload_length (out_payload_length),
    .out_subfunction    (out_subfunction),
    .out_notify         (out_notify)
  );

endmodule

`default_nettype wire

>>> sim/frame_scoreboard_pkg.sv
// frame parser predictor and result scoreboard for the addressed frame receiver testbench
`timescale 1ns / 100ps

package frame_scoreboard_pkg;

  // number of header bytes, start byte included
  localparam logic [15:0] HEADER_LEN = 16'd5;

  // one result word as seen on the out channel
  typedef struct packed {
    logic              kind;
    logic [15:0]       payload_index;
    logic [7:0]        payload_byte;
    logic [7:0]        frame_function;
    logic [15:0]       payload_length;
    logic [7:0]        subfunction;
    afr_pkg::notify_t  notify;
  } frame_result_t;

  class frame_scoreboard;

    // predicted parser state
    afr_pkg::phase_t phase     = afr_pkg::PH_IDLE;
    logic [15:0]     count     = 16'd0;
    logic [7:0]      hdr_addr  = 8'd0;
    logic [7:0]      hdr_func  = 8'd0;
    logic [15:0]     hdr_len   = 16'd0;
    logic [7:0]      first_pl  = 8'd0;
    logic [7:0]      node_addr = 8'd0;

    // results still owed by the block, oldest first
    frame_result_t owed_results[$];
    int unsigned   mismatches = 0;

    function void set_node(logic [7:0] addr);
      node_addr = addr;
    endfunction

    // step the parser by one accepted input word
    function void note_byte(logic [7:0] b);
      frame_result_t r;
      bit            done;
      bit            emit;
      r    = '0;
      done = 1'b0;
      emit = 1'b0;

      // payload bytes, then the end byte that closes the frame
      if (phase == afr_pkg::PH_PAYLOAD) begin
        if (count < hdr_len) begin
          if (count == 16'd0) first_pl = b;
          r.kind          = afr_pkg::KIND_PAYLOAD;
          r.payload_index = count;
          r.payload_byte  = b;
          emit            = 1'b1;
          count           = count + 16'd1;
        end else begin
          phase = afr_pkg::PH_IDLE;
          count = 16'd0;
          done  = 1'b1;
        end
      end

      // hunt for a start byte, the end byte never opens a frame
      if (phase == afr_pkg::PH_IDLE && !done && b == afr_pkg::START_BYTE) begin
        phase = afr_pkg::PH_HEADER;
        count = 16'd0;
      end

      // collect header fields
      if (phase == afr_pkg::PH_HEADER && count < HEADER_LEN) begin
        case (count)
          afr_pkg::HDR_ADDR:   hdr_addr = b;
          afr_pkg::HDR_FUNC:   hdr_func = b;
          afr_pkg::HDR_LEN_LO: hdr_len[7:0] = b;
          afr_pkg::HDR_LEN_HI: hdr_len[15:8] = b;
          default: ;
        endcase
        count = count + 16'd1;
      end

      // address check on the last header byte
      if (phase == afr_pkg::PH_HEADER && count == HEADER_LEN) begin
        phase = (hdr_addr == node_addr) ? afr_pkg::PH_PAYLOAD : afr_pkg::PH_IDLE;
        count = 16'd0;
      end

      // frame complete word
      if (done) begin
        r.kind           = afr_pkg::KIND_COMPLETE;
        r.frame_function = hdr_func;
        r.payload_length = hdr_len;
        r.subfunction    = first_pl;
        if (hdr_func == afr_pkg::FUNC_TIME)      r.notify = afr_pkg::NOTIFY_TIME;
        else if (hdr_func == afr_pkg::FUNC_TEST) r.notify = afr_pkg::NOTIFY_TEST;
        else                                     r.notify = afr_pkg::NOTIFY_NONE;
        emit = 1'b1;
      end

      if (emit) owed_results.push_back(r);
    endfunction

    // compare one accepted result word with the oldest owed one
    function void check_result(frame_result_t got);
      frame_result_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected word kind %0d idx %0d byte %h func %h len %0d",
                   got.kind, got.payload_index, got.payload_byte, got.frame_function,
                   got.payload_length);
        return;
      end
      want = owed_results.pop_front();
      if (got.kind !== want.kind || got.payload_index !== want.payload_index ||
          got.payload_byte !== want.payload_byte ||
          got.frame_function !== want.frame_function ||
          got.payload_length !== want.payload_length ||
          got.subfunction !== want.subfunction || got.notify !== want.notify) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected kind %0d idx %0d byte %h func %h len %0d sub %h ntf %0d",
                   want.kind, want.payload_index, want.payload_byte, want.frame_function,
                   want.payload_length, want.subfunction, want.notify);
          $display("          actual   kind %0d idx %0d byte %h func %h len %0d sub %h ntf %0d",
                   got.kind, got.payload_index, got.payload_byte, got.frame_function,
                   got.payload_length, got.subfunction, got.notify);
        end
      end
    endfunction

  endclass

endpackage

>>> sim/testbench.sv
// top-level testbench for the addressed frame receiver
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 150;

  // directed opening: noise, zero length after reset, start bytes as data,
  // dropped header followed at once by a new frame, repeated subfunction
  localparam logic [7:0] DIRECTED [27] = '{
    8'h00, 8'hFF,
    afr_pkg::START_BYTE, 8'h00, afr_pkg::FUNC_TIME, 8'h00, 8'h00,
    afr_pkg::START_BYTE,
    afr_pkg::START_BYTE, 8'h00, afr_pkg::START_BYTE, 8'h02, 8'h00,
    afr_pkg::START_BYTE, 8'hFF, afr_pkg::START_BYTE,
    afr_pkg::START_BYTE, 8'h01, afr_pkg::FUNC_TEST, 8'h00, 8'h00,
    afr_pkg::START_BYTE, 8'h00, afr_pkg::FUNC_TEST, 8'h00, 8'h00, 8'h55
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_kind;
  logic [15:0] out_payload_index;
  logic [7:0]  out_payload_byte;
  logic [7:0]  out_frame_function;
  logic [15:0] out_payload_length;
  logic [7:0]  out_subfunction;
  logic [1:0]  out_notify;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_node_address;

  frame_scoreboard_pkg::frame_scoreboard sb;
  bit              in_calm;
  bit              out_calm;
  int              stim_items;
  int              cycle_count;
  logic [7:0]      node_now;

  addressed_frame_receiver DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_payload_index  (out_payload_index),
    .out_payload_byte   (out_payload_byte),
    .out_frame_function (out_frame_function),
    .out_payload_length (out_payload_length),
    .out_subfunction    (out_subfunction),
    .out_notify         (out_notify),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_node_address   (cfg_node_address)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench failed");
    $finish;
  end

  // send one input word, idling first for a random number of cycles
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
  endtask

  // random payload byte, start bytes mixed in as data
  function automatic logic [7:0] data_byte();
    return ($urandom_range(0, 7) == 0) ? afr_pkg::START_BYTE : 8'($urandom_range(0, 255));
  endfunction

  // random function code, both notify codes well represented
  function automatic logic [7:0] func_byte();
    case ($urandom_range(0, 3))
      0:       return afr_pkg::FUNC_TIME;
      1:       return afr_pkg::FUNC_TEST;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // whole frame: header, payload, end byte
  task automatic send_frame(input logic [7:0] addr, input logic [15:0] len);
    push_byte(afr_pkg::START_BYTE);
    push_byte(addr);
    push_byte(func_byte());
    push_byte(len[7:0]);
    push_byte(len[15:8]);
    for (int i = 0; i < len; i++) push_byte(data_byte());
    push_byte(data_byte());
    stim_items += 6 + len;
  endtask

  // drain all owed results, then let the pipeline settle
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // node address write while the block is idle
  task automatic write_node(input logic [7:0] addr);
    settle();
    cfg_valid        <= 1'b1;
    cfg_node_address <= addr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_node(addr);
    node_now = addr;
  endtask

  // random traffic: mostly good frames, some foreign, truncated and noise
  task automatic random_phase(input bit with_long);
    int          pick;
    int          n;
    logic [15:0] len;
    if (with_long) send_frame(node_now, 16'd260);
    stim_items = 0;
    while (stim_items < PHASE_ITEMS) begin
      in_calm = ($urandom_range(0, 3) == 0);
      pick    = $urandom_range(0, 99);
      len     = ($urandom_range(0, 6) == 0) ? 16'($urandom_range(11, 48))
                                            : 16'($urandom_range(0, 10));
      if (pick < 65) begin
        send_frame(node_now, len);
      end else if (pick < 77) begin
        send_frame(node_now ^ 8'($urandom_range(1, 255)), len);
      end else if (pick < 87) begin
        // header cut short, later bytes land in it
        n = $urandom_range(1, 4);
        push_byte(afr_pkg::START_BYTE);
        for (int i = 1; i < n; i++) push_byte(8'($urandom_range(0, 255)));
        stim_items += n;
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
        stim_items += n;
      end
    end
  endtask

  // result side: random stalls, check each accepted word
  initial begin
    int                                 gap;
    frame_scoreboard_pkg::frame_result_t got;
    out_ready <= 1'b0;
    out_calm  = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if ($urandom_range(0, 31) == 0) out_calm = ~out_calm;
      gap = out_calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.kind           = out_kind;
      got.payload_index  = out_payload_index;
      got.payload_byte   = out_payload_byte;
      got.frame_function = out_frame_function;
      got.payload_length = out_payload_length;
      got.subfunction    = out_subfunction;
      got.notify         = afr_pkg::notify_t'(out_notify);
      sb.check_result(got);
    end
  end

  // stimulus
  initial begin
    sb               = new;
    rst_n            <= 1'b0;
    in_valid         <= 1'b0;
    in_rx_byte       <= 8'h00;
    cfg_valid        <= 1'b0;
    cfg_node_address <= 8'h00;
    in_calm          = 1'b0;
    node_now         = 8'h00;
    stim_items       = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words with the reset node address
    foreach (DIRECTED[i]) push_byte(DIRECTED[i]);

    // random traffic under several node addresses, extremes included
    write_node(8'hFF);
    random_phase(1'b1);
    write_node(8'h00);
    random_phase(1'b0);
    write_node(8'($urandom_range(1, 254)));
    random_phase(1'b0);
    write_node(8'hFF);
    random_phase(1'b0);
    write_node(8'($urandom_range(0, 255)));
    random_phase(1'b0);

    // wait out the tail
    settle();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed_results.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
